// ===== rtl/core/bblur_pkg.sv =====
package bblur_pkg;

  // Frame and window limits.
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_WINDOW = 15;

  // Derived widths.
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int DIM_W  = 7;
  localparam int WIN_W  = 4;
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int POS_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;
  localparam int SUM_W  = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
  localparam int CNT_W  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int STEP_W = $clog2(SUM_W + 1);

  // Configuration port.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WINDOW_SIZE  = 2'd2;

  // Command codes.
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CH_W-1:0]  chan_t;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [WIN_W-1:0] window_size;
  } cfg_regs_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Frame dimension as used: zero acts as one, large values saturate.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

  // Window side as used.
  function automatic logic [WIN_W-1:0] clamp_win(input logic [WIN_W-1:0] v);
    logic [WIN_W-1:0] r;
    r = v;
    if (v == '0) r = WIN_W'(1);
    else if (32'(v) > MAX_WINDOW) r = WIN_W'(MAX_WINDOW);
    return r;
  endfunction

endpackage

// ===== rtl/core/bblur_if.sv =====
interface bblur_in_if;
  import bblur_pkg::*;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [CH_W-1:0]  red_in;
  logic [CH_W-1:0]  green_in;
  logic [CH_W-1:0]  blue_in;

  modport source (output valid, cmd, col, row, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, cmd, col, row, red_in, green_in, blue_in, output ready);
endinterface

interface bblur_out_if;
  import bblur_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_avg;
  logic [CH_W-1:0] green_avg;
  logic [CH_W-1:0] blue_avg;

  modport source (output valid, red_avg, green_avg, blue_avg, input ready);
  modport sink   (input valid, red_avg, green_avg, blue_avg, output ready);
endinterface

// ===== rtl/core/bblur_cfg.sv =====
module bblur_cfg
  import bblur_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_regs_t         regs
);

  cfg_regs_t  regs_r;
  logic [1:0] reg_idx;
  logic       wr_hit;

  assign reg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_pready = 1'b1;
  assign wr_hit     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign regs       = regs_r;

  // Register writes in the access phase; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.frame_width  <= DIM_W'(MAX_WIDTH);
      regs_r.frame_height <= DIM_W'(MAX_HEIGHT);
      regs_r.window_size  <= WIN_W'(3);
    end else if (wr_hit) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  regs_r.frame_width  <= cfg_pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: regs_r.frame_height <= cfg_pwdata[DIM_W-1:0];
        REG_WINDOW_SIZE:  regs_r.window_size  <= cfg_pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  cfg_prdata = CFG_DW'(regs_r.frame_width);
      REG_FRAME_HEIGHT: cfg_prdata = CFG_DW'(regs_r.frame_height);
      REG_WINDOW_SIZE:  cfg_prdata = CFG_DW'(regs_r.window_size);
      default:          cfg_prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/bblur_frame_mem.sv =====
module bblur_frame_mem
  import bblur_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [PIX_W-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [PIX_W-1:0]  rd_data
);

  logic [PIX_W-1:0] mem [1 << ADDR_W];
  logic [PIX_W-1:0] rd_data_r;

  assign rd_data = rd_data_r;

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/bblur_div.sv =====
module bblur_div
  import bblur_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  sum_t      dividend [3],
  input  cnt_t      divisor,
  output div_stat_t stat,
  output chan_t     quotient [3]
);

  logic [CNT_W-1:0]  rem_r [3];
  logic [CNT_W-1:0]  rem_nxt [3];
  logic [SUM_W-1:0]  quo_r [3];
  logic [SUM_W-1:0]  quo_nxt [3];
  logic [CNT_W:0]    shifted [3];
  logic [STEP_W-1:0] step_r;
  logic              done_r;

  assign stat.busy = (step_r != '0);
  assign stat.done = done_r;

  // One restoring step per cycle on each of the three channels.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      shifted[c] = {rem_r[c], quo_r[c][SUM_W-1]};
      if (shifted[c] >= {1'b0, divisor}) begin
        rem_nxt[c] = CNT_W'(shifted[c] - {1'b0, divisor});
        quo_nxt[c] = {quo_r[c][SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt[c] = shifted[c][CNT_W-1:0];
        quo_nxt[c] = {quo_r[c][SUM_W-2:0], 1'b0};
      end
      quotient[c] = quo_r[c][CH_W-1:0];
    end
  end

  // Step counter and completion flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      step_r <= STEP_W'(SUM_W);
      done_r <= 1'b0;
    end else if (step_r != '0) begin
      step_r <= step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) done_r <= 1'b1;
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (start) begin
        rem_r[c] <= '0;
        quo_r[c] <= dividend[c];
      end else if (step_r != '0) begin
        rem_r[c] <= rem_nxt[c];
        quo_r[c] <= quo_nxt[c];
      end
    end
  end

endmodule

// ===== rtl/core/box_blur_window_average.sv =====
// Box blur over a stored RGB frame of up to 64 by 64 pixels. A store beat
// (cmd 0) writes one pixel into the frame memory; stores outside the
// configured frame are dropped. A read beat (cmd 1) returns the truncated
// per-channel mean over a window_size square whose top-left corner sits
// (window_size-1)/2 left of and above the addressed pixel, counting only
// pixels inside the frame; an empty window returns zeros. During a read the
// frame memory's single read port delivers one window pixel per cycle, after
// which a bit-serial divider works out the three means. One read is in flight
// at a time, and a finished result waits in an output register while new
// beats are accepted. The frame memory is not cleared at reset; a pixel must
// be stored before any window covers it. Configuration may only change while
// the block is idle.
module box_blur_window_average
  import bblur_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  bblur_in_if.sink          in_ch,
  bblur_out_if.source       out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_START = 5'b01000,
    ST_DIV   = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  cfg_regs_t        regs;
  logic [DIM_W-1:0] eff_w, eff_h;
  logic [WIN_W-1:0] eff_k, half_k;

  logic             in_acc, out_free;
  logic [WIN_W-1:0] i_r, j_r;
  logic signed [POS_W-1:0] x0_r, y0_r, xs, ys;
  logic             x_ok, y_ok, last_pos;

  logic              wr_en, rd_en, rd_pend_r;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [PIX_W-1:0]  wr_data, rd_data;

  sum_t      sum_r [3];
  cnt_t      cnt_r;
  div_stat_t div_stat;
  chan_t     quo [3];
  logic      div_start;

  logic  out_valid_r;
  chan_t out_red_r, out_green_r, out_blue_r;

  bblur_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .regs        (regs)
  );

  // Effective geometry.
  assign eff_w  = clamp_dim(regs.frame_width, DIM_W'(MAX_WIDTH));
  assign eff_h  = clamp_dim(regs.frame_height, DIM_W'(MAX_HEIGHT));
  assign eff_k  = clamp_win(regs.window_size);
  assign half_k = (eff_k - WIN_W'(1)) >> 1;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Store path: written in the accept cycle when the pixel is inside the frame.
  assign wr_en   = in_acc && (in_ch.cmd == CMD_STORE) &&
                   ({1'b0, in_ch.col} < eff_w) && ({1'b0, in_ch.row} < eff_h);
  assign wr_addr = {in_ch.row, in_ch.col};
  assign wr_data = {in_ch.red_in, in_ch.green_in, in_ch.blue_in};

  // Window position under scan and its bounds check.
  assign xs       = x0_r + POS_W'(j_r);
  assign ys       = y0_r + POS_W'(i_r);
  assign x_ok     = !xs[POS_W-1] && (xs[DIM_W-1:0] < eff_w);
  assign y_ok     = !ys[POS_W-1] && (ys[DIM_W-1:0] < eff_h);
  assign last_pos = (i_r == eff_k - WIN_W'(1)) && (j_r == eff_k - WIN_W'(1));
  assign rd_en    = (state_r == ST_SCAN) && x_ok && y_ok;
  assign rd_addr  = {ys[ROW_W-1:0], xs[COL_W-1:0]};

  bblur_frame_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign div_start = (state_r == ST_START);

  bblur_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .stat     (div_stat),
    .quotient (quo)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && in_ch.cmd == CMD_READ) state_nxt = ST_SCAN;
      ST_SCAN:  if (last_pos) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   if (div_stat.done && out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_en;
    end
  end

  // Window origin and scan counters, row by row.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      x0_r <= POS_W'(in_ch.col) - POS_W'(half_k);
      y0_r <= POS_W'(in_ch.row) - POS_W'(half_k);
      i_r  <= '0;
      j_r  <= '0;
    end else if (state_r == ST_SCAN) begin
      if (j_r == eff_k - WIN_W'(1)) begin
        j_r <= '0;
        i_r <= i_r + WIN_W'(1);
      end else begin
        j_r <= j_r + WIN_W'(1);
      end
    end
  end

  // Accumulate each pixel in the cycle after its read is issued.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      for (int c = 0; c < 3; c++) sum_r[c] <= '0;
      cnt_r <= '0;
    end else if (rd_pend_r) begin
      sum_r[0] <= sum_r[0] + SUM_W'(rd_data[3*CH_W-1:2*CH_W]);
      sum_r[1] <= sum_r[1] + SUM_W'(rd_data[2*CH_W-1:CH_W]);
      sum_r[2] <= sum_r[2] + SUM_W'(rd_data[CH_W-1:0]);
      cnt_r    <= cnt_r + CNT_W'(1);
    end
  end

  // Output register; an empty window gives zeros.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DIV && div_stat.done && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV && div_stat.done && out_free) begin
      out_red_r   <= (cnt_r == '0) ? '0 : quo[0];
      out_green_r <= (cnt_r == '0) ? '0 : quo[1];
      out_blue_r  <= (cnt_r == '0) ? '0 : quo[2];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_avg   = out_red_r;
  assign out_ch.green_avg = out_green_r;
  assign out_ch.blue_avg  = out_blue_r;

endmodule

// ===== rtl/core/bblur_checker.sv =====
module bblur_checker
  import bblur_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_cmd,
  input logic            out_valid,
  input logic            out_ready,
  input logic [CH_W-1:0] out_red_avg,
  input logic [CH_W-1:0] out_green_avg,
  input logic [CH_W-1:0] out_blue_avg
);

  // A read beat keeps the block busy for its window scan.
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_READ |=> !in_ready)
    else $error("input ready after a read beat");

  // A store beat completes in its own cycle.
  a_store_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_STORE |=> in_ready)
    else $error("block busy after a store beat");

  // A result only appears after a read was being worked on.
  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a read in progress");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red_avg) &&
      $stable(out_green_avg) && $stable(out_blue_avg))
    else $error("stalled result changed");

endmodule

bind box_blur_window_average bblur_checker u_bblur_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_cmd        (in_ch.cmd),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_red_avg   (out_ch.red_avg),
  .out_green_avg (out_ch.green_avg),
  .out_blue_avg  (out_ch.blue_avg)
);

// ===== test/blur_checker.sv =====
module blur_checker
  import bblur_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  bblur_in_if               in_mon,
  bblur_out_if              out_mon,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic              cfg_pready,
  output int                fail_count,
  output int                pending_count,
  output int                beat_count,
  output int                read_count,
  output int                result_count
);

  localparam int WINDOW_AT_RESET = 3;
  localparam int PRINT_CAP       = 100;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } blur_rgb_t;

  // Shadow of the frame memory and the registers, as the block should hold them.
  logic [PIX_W-1:0] frame_copy [MAX_WIDTH*MAX_HEIGHT];
  logic [DIM_W-1:0] cfg_width;
  logic [DIM_W-1:0] cfg_height;
  logic [WIN_W-1:0] cfg_window;

  // Window means owed to the result channel, oldest first.
  blur_rgb_t        owed_means_q[$];
  blur_rgb_t        got_mean;
  blur_rgb_t        want_mean;
  int               n_mismatch;
  int               n_beats;
  int               n_reads;
  int               n_results;

  // Register value as the block uses it: zero acts as one, large values saturate.
  function automatic int used_size(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Truncated per-channel mean over the in-frame part of the window.
  function automatic blur_rgb_t window_mean(input int c, input int r);
    int          w;
    int          h;
    int          k;
    int          half;
    int          x;
    int          y;
    int unsigned sum_r;
    int unsigned sum_g;
    int unsigned sum_b;
    int unsigned n;
    logic [PIX_W-1:0] px;
    blur_rgb_t   m;
    w = used_size(int'(cfg_width), MAX_WIDTH);
    h = used_size(int'(cfg_height), MAX_HEIGHT);
    k = used_size(int'(cfg_window), MAX_WINDOW);
    half = (k - 1) / 2;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    n = 0;
    for (y = r - half; y < r - half + k; y++) begin
      for (x = c - half; x < c - half + k; x++) begin
        if (y >= 0 && y < h && x >= 0 && x < w) begin
          px = frame_copy[y*MAX_WIDTH + x];
          sum_r += px[3*CH_W-1:2*CH_W];
          sum_g += px[2*CH_W-1:CH_W];
          sum_b += px[CH_W-1:0];
          n++;
        end
      end
    end
    m = '0;
    // An empty window reports zeros on every channel.
    if (n != 0) begin
      m.red   = chan_t'(sum_r / n);
      m.green = chan_t'(sum_g / n);
      m.blue  = chan_t'(sum_b / n);
    end
    return m;
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_mismatch < PRINT_CAP) begin
      $display("blur_checker: mismatch at %0t: %s", $time, msg);
    end
    n_mismatch++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_width  = DIM_W'(MAX_WIDTH);
      cfg_height = DIM_W'(MAX_HEIGHT);
      cfg_window = WIN_W'(WINDOW_AT_RESET);
      owed_means_q.delete();
      n_mismatch = 0;
      n_beats    = 0;
      n_reads    = 0;
      n_results  = 0;
    end else begin
      // A result beat is matched against the oldest owed mean.
      if (out_mon.valid && out_mon.ready) begin
        got_mean.red   = out_mon.red_avg;
        got_mean.green = out_mon.green_avg;
        got_mean.blue  = out_mon.blue_avg;
        if (owed_means_q.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d/%0d arrived with no read outstanding",
                                    got_mean.red, got_mean.green, got_mean.blue));
        end else begin
          want_mean = owed_means_q.pop_front();
          if (got_mean.red !== want_mean.red)
            report_mismatch($sformatf("result %0d red_avg is %0d, expected %0d",
                                      n_results, got_mean.red, want_mean.red));
          if (got_mean.green !== want_mean.green)
            report_mismatch($sformatf("result %0d green_avg is %0d, expected %0d",
                                      n_results, got_mean.green, want_mean.green));
          if (got_mean.blue !== want_mean.blue)
            report_mismatch($sformatf("result %0d blue_avg is %0d, expected %0d",
                                      n_results, got_mean.blue, want_mean.blue));
          n_results++;
        end
      end

      // Register writes land in the shadow copy; unmapped addresses are dropped.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_AW-1:2])
          REG_FRAME_WIDTH:  cfg_width  = cfg_pwdata[DIM_W-1:0];
          REG_FRAME_HEIGHT: cfg_height = cfg_pwdata[DIM_W-1:0];
          REG_WINDOW_SIZE:  cfg_window = cfg_pwdata[WIN_W-1:0];
          default: ;
        endcase
      end

      // Input beats: reads owe a mean, stores inside the frame update the shadow.
      if (in_mon.valid && in_mon.ready) begin
        n_beats++;
        if (in_mon.cmd == CMD_READ) begin
          owed_means_q.push_back(window_mean(int'(in_mon.col), int'(in_mon.row)));
          n_reads++;
        end else if (int'(in_mon.col) < used_size(int'(cfg_width), MAX_WIDTH) &&
                     int'(in_mon.row) < used_size(int'(cfg_height), MAX_HEIGHT)) begin
          frame_copy[{in_mon.row, in_mon.col}] = {in_mon.red_in, in_mon.green_in,
                                                  in_mon.blue_in};
        end
      end
    end
    fail_count    <= n_mismatch;
    pending_count <= owed_means_q.size();
    beat_count    <= n_beats;
    read_count    <= n_reads;
    result_count  <= n_results;
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import bblur_pkg::*;

  localparam logic [1:0] REG_UNMAPPED   = 2'd3;
  localparam int         ITEM_TARGET    = 1550;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         DRAIN_CYCLES   = 300;
  localparam int         FIXED_PHASES   = 6;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  bblur_in_if  in_ch();
  bblur_out_if out_ch();

  int fail_count;
  int pending_count;
  int beat_count;
  int read_count;
  int result_count;

  // Stimulus-side view of the frame: which pixels hold data, and the sizes in use.
  bit pix_written [MAX_HEIGHT][MAX_WIDTH];
  int eff_w;
  int eff_h;
  int eff_k;
  int items_sent;
  int settings_used;
  bit steady;

  always #6 clk = ~clk;

  box_blur_window_average u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  blur_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .beat_count    (beat_count),
    .read_count    (read_count),
    .result_count  (result_count)
  );

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (steady) return 0;
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int effective(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Frame size code, biased to small frames with the odd out-of-range value.
  function automatic int pick_dim();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(12, 1);
    if (roll < 85) return $urandom_range(64, 13);
    if (roll < 90) return MAX_WIDTH;
    if (roll < 95) return 0;
    return $urandom_range(127, 65);
  endfunction

  // Result side: stalls of random length between stretches of ready.
  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // One beat on the input channel, after an optional gap; returns at acceptance.
  task automatic drive_beat(input logic cmd, input int col, input int row,
                            input logic [PIX_W-1:0] rgb);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= cmd;
    in_ch.col      <= COL_W'(col);
    in_ch.row      <= ROW_W'(row);
    in_ch.red_in   <= rgb[3*CH_W-1:2*CH_W];
    in_ch.green_in <= rgb[2*CH_W-1:CH_W];
    in_ch.blue_in  <= rgb[CH_W-1:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (cmd == CMD_READ) begin
      items_sent++;
    end else if (col < eff_w && row < eff_h) begin
      items_sent++;
      pix_written[row][col] = 1'b1;
    end
  endtask

  task automatic store_pixel(input int col, input int row);
    drive_beat(CMD_STORE, col, row, PIX_W'($urandom));
  endtask

  // Read a blurred pixel, first storing any in-frame window pixel still empty.
  task automatic blur_read(input int col, input int row);
    int half;
    int x;
    int y;
    half = (eff_k - 1) / 2;
    for (y = row - half; y < row - half + eff_k; y++) begin
      for (x = col - half; x < col - half + eff_k; x++) begin
        if (x >= 0 && x < eff_w && y >= 0 && y < eff_h && !pix_written[y][x]) begin
          store_pixel(x, y);
        end
      end
    end
    drive_beat(CMD_READ, col, row, PIX_W'($urandom));
  endtask

  // Stop sending until every outstanding read has returned its result.
  task automatic hold_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Setup and access cycle of one register write; the caller releases the bus.
  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
  endtask

  // New frame settings, written only once the block has gone idle.
  task automatic set_frame(input int w_code, input int h_code, input int k_code,
                           input bit poke_unmapped);
    hold_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (poke_unmapped) cfg_write(REG_UNMAPPED, $urandom);
    cfg_write(REG_FRAME_WIDTH, CFG_DW'(w_code));
    cfg_write(REG_FRAME_HEIGHT, CFG_DW'(h_code));
    cfg_write(REG_WINDOW_SIZE, CFG_DW'(k_code));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    eff_w = effective(w_code, MAX_WIDTH);
    eff_h = effective(h_code, MAX_HEIGHT);
    eff_k = effective(k_code, MAX_WINDOW);
    settings_used++;
  endtask

  initial begin
    int fixed_w [FIXED_PHASES];
    int fixed_h [FIXED_PHASES];
    int fixed_k [FIXED_PHASES];
    int phase_no;
    int ops;
    int roll;
    int k_code;
    int i;
    fixed_w = '{64, 0, 64, 1, 127, 13};
    fixed_h = '{64, 0, 1, 64, 127, 7};
    fixed_k = '{15, 0, 2, 15, 1, 6};
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= CMD_STORE;
    in_ch.col      <= '0;
    in_ch.row      <= '0;
    in_ch.red_in   <= '0;
    in_ch.green_in <= '0;
    in_ch.blue_in  <= '0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    steady         = 1'b0;
    items_sent     = 0;
    settings_used  = 1;
    eff_w          = MAX_WIDTH;
    eff_h          = MAX_HEIGHT;
    eff_k          = 3;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Top-left corner at reset sizes: saturated and empty channels mixed.
    drive_beat(CMD_STORE, 0, 0, 24'hFFFFFF);
    drive_beat(CMD_STORE, 1, 0, 24'h000000);
    drive_beat(CMD_STORE, 0, 1, 24'hFF00FF);
    drive_beat(CMD_STORE, 1, 1, 24'h00FF00);
    blur_read(0, 0);

    // Bottom-right corner, with a sum that must truncate.
    drive_beat(CMD_STORE, 63, 63, 24'hFFFFFF);
    drive_beat(CMD_STORE, 62, 63, 24'hFFFFFF);
    drive_beat(CMD_STORE, 63, 62, 24'hFFFFFF);
    drive_beat(CMD_STORE, 62, 62, 24'hFFFFFE);
    blur_read(63, 63);
    drive_beat(CMD_STORE, 63, 0, 24'h010203);
    blur_read(63, 0);
    hold_for_results();

    // Zero width and window act as one, oversized height saturates.
    // A store off the frame is dropped and a read off it sees an empty window.
    set_frame(0, 127, 0, 1'b1);
    drive_beat(CMD_STORE, 5, 3, 24'hABCDEF);
    blur_read(40, 3);
    blur_read(5, 3);
    blur_read(0, 0);
    blur_read(0, 63);

    // Even window: one column and row before the pixel, two after.
    set_frame(8, 6, 4, 1'b0);
    blur_read(7, 5);
    blur_read(0, 0);

    // Random phases, starting with the extreme settings, which all run.
    phase_no = 0;
    while (items_sent < ITEM_TARGET || phase_no < FIXED_PHASES) begin
      if (phase_no < FIXED_PHASES) begin
        set_frame(fixed_w[phase_no], fixed_h[phase_no], fixed_k[phase_no], 1'b0);
      end else begin
        roll = $urandom_range(99);
        if (roll < 70) k_code = $urandom_range(7, 1);
        else if (roll < 90) k_code = $urandom_range(15, 8);
        else if (roll < 95) k_code = 0;
        else k_code = MAX_WINDOW;
        set_frame(pick_dim(), pick_dim(), k_code, $urandom_range(7) == 0);
      end
      steady = ($urandom_range(4) == 0);
      // Large windows on large frames pull in many fill stores per read.
      if (eff_w * eff_h > 256 && eff_k > 7) ops = $urandom_range(8, 4);
      else ops = $urandom_range(60, 20);
      for (i = 0; i < ops; i++) begin
        roll = $urandom_range(99);
        if (roll < 50) blur_read($urandom_range(eff_w - 1), $urandom_range(eff_h - 1));
        else if (roll < 65) blur_read($urandom_range(63), $urandom_range(63));
        else if (roll < 90) store_pixel($urandom_range(eff_w - 1), $urandom_range(eff_h - 1));
        else store_pixel($urandom_range(63), $urandom_range(63));
        if ($urandom_range(49) == 0) hold_for_results();
      end
      phase_no++;
    end

    // Let the last results come out, then give any stray beat time to show.
    steady = 1'b0;
    hold_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb_top: %0d beats accepted, %0d of them window reads; %0d results compared",
             beat_count, read_count, result_count);
    $display("tb_top: %0d frame settings, from 1x1 to 64x64 with windows of 1 to 15",
             settings_used);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #60000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bblur_pkg.sv
rtl/core/bblur_if.sv
rtl/core/bblur_cfg.sv
rtl/core/bblur_frame_mem.sv
rtl/core/bblur_div.sv
rtl/core/box_blur_window_average.sv
rtl/core/bblur_checker.sv
test/blur_checker.sv
test/tb_top.sv
